@@ src/srbna_pkg.sv @@
// ----------------------------------------------------------------------------
// srbna_pkg
// Shared constants, types and helpers for the scan ring buffer.
// ----------------------------------------------------------------------------
package srbna_pkg;

    localparam int SLOTS        = 8;
    localparam int MAX_ELEMS    = 2048;
    localparam int FIELD_TENTHS = 1800;
    localparam int DIST_W       = 16;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ELEM_W  = $clog2(MAX_ELEMS);
    localparam int FILL_W  = ELEM_W + 1;
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int ADDR_W  = SLOT_W + ELEM_W;
    localparam int DEPTH   = SLOTS * MAX_ELEMS;

    // angle divider: dividend 2*angle + r, divisor 2*r
    localparam int DVD_W = 13;
    localparam int DIV_W = 5;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_OVWR  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] reading;
        logic        last_reading;
        logic [10:0] element_index;
        logic        release_after;
        logic [10:0] angle_tenths;
    } item_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [1:0]  status;
        logic [3:0]  count;
    } result_t;

    function automatic logic [3:0] res_eff(input logic [3:0] r);
        if (r == 4'd0)
            return 4'd1;
        else if (r > 4'd10)
            return 4'd10;
        else
            return r;
    endfunction

    // elements per scan, capped at MAX_ELEMS
    function automatic logic [FILL_W-1:0] elems(input logic [3:0] r);
        int e;
        case (res_eff(r))
            4'd1:    e = FIELD_TENTHS / 1 + 1;
            4'd2:    e = FIELD_TENTHS / 2 + 1;
            4'd3:    e = FIELD_TENTHS / 3 + 1;
            4'd4:    e = FIELD_TENTHS / 4 + 1;
            4'd5:    e = FIELD_TENTHS / 5 + 1;
            4'd6:    e = FIELD_TENTHS / 6 + 1;
            4'd7:    e = FIELD_TENTHS / 7 + 1;
            4'd8:    e = FIELD_TENTHS / 8 + 1;
            4'd9:    e = FIELD_TENTHS / 9 + 1;
            default: e = FIELD_TENTHS / 10 + 1;
        endcase
        if (e > MAX_ELEMS)
            e = MAX_ELEMS;
        return FILL_W'(e);
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

@@ src/srbna_front.sv @@
// ----------------------------------------------------------------------------
// srbna_front
// Two-entry command queue between the input port and the execution engine.
// ----------------------------------------------------------------------------
module srbna_front
    import srbna_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  item_t       in_item,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t       slot_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push;
    logic        do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = do_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/srbna_back.sv @@
// ----------------------------------------------------------------------------
// srbna_back
// Execution engine: scan memory, ring pointers, padding, angle divider, result.
// ----------------------------------------------------------------------------
module srbna_back
    import srbna_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  res_cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        res_valid,
    output result_t     res,
    input  logic        res_pop
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;

    logic [DIST_W-1:0]  mem [DEPTH];
    logic [DIST_W-1:0]  rdata_reg;

    logic [2:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  pad_reg, pad_next;
    logic [1:0]         pend_reg, pend_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dsr_reg, dsr_next;
    logic [3:0]         step_reg, step_next;
    logic               rv_reg, rv_next;
    result_t            res_reg, res_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [DIST_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;

    logic [FILL_W-1:0]  e;
    logic [3:0]         r;
    logic               ovw;
    logic [COUNT_W-1:0] cnt_tmp;
    logic [1:0]         st_tmp;
    logic [FILL_W-1:0]  fill_w;
    logic [DIV_W:0]     rem_s;
    logic               qbit;
    logic [DVD_W-1:0]   quot;

    assign r         = res_eff(res_cfg);
    assign e         = elems(res_cfg);
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        wslot_next  = wslot_reg;
        count_next  = count_reg;
        fill_next   = fill_reg;
        pad_next    = pad_reg;
        pend_next   = pend_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        step_next   = step_reg;
        rv_next     = rv_reg && !res_pop;
        res_next    = res_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;
        ovw         = 1'b0;
        cnt_tmp     = count_reg;
        st_tmp      = ST_OK;
        fill_w      = fill_reg;
        rem_s       = {rem_reg, dvd_reg[DVD_W-1]};
        qbit        = (rem_s >= {1'b0, dsr_reg});
        quot        = {dvd_reg[DVD_W-2:0], qbit};

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !rv_reg)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.opcode)
                        OP_PUSH:
                        begin
                            ovw = (fill_reg == '0) && (count_reg >= COUNT_W'(SLOTS));
                            if (ovw)
                            begin
                                oldest_next = next_slot(oldest_reg);
                                cnt_tmp     = COUNT_W'(SLOTS - 1);
                                st_tmp      = ST_OVWR;
                            end
                            if (fill_reg < e)
                            begin
                                we     = 1'b1;
                                waddr  = {wslot_reg, fill_reg[ELEM_W-1:0]};
                                wdata  = q_item.reading;
                                fill_w = fill_reg + 1'b1;
                            end
                            if (q_item.last_reading && (fill_w < e))
                            begin
                                // zero-fill the tail of a short scan
                                pad_next   = fill_w;
                                pend_next  = st_tmp;
                                count_next = cnt_tmp;
                                state_next = S_PAD;
                            end
                            else if (q_item.last_reading)
                            begin
                                wslot_next = next_slot(wslot_reg);
                                count_next = cnt_tmp + 1'b1;
                                fill_next  = '0;
                                rv_next    = 1'b1;
                                res_next   = '{16'd0, st_tmp, 4'(cnt_tmp + 1'b1)};
                            end
                            else
                            begin
                                fill_next  = fill_w;
                                count_next = cnt_tmp;
                                rv_next    = 1'b1;
                                res_next   = '{16'd0, st_tmp, 4'(cnt_tmp)};
                            end
                        end
                        OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                rv_next  = 1'b1;
                                res_next = '{16'd0, ST_EMPTY, 4'(count_reg)};
                            end
                            else if ({1'b0, q_item.element_index} >= e)
                            begin
                                rv_next  = 1'b1;
                                res_next = '{16'd0, ST_RANGE, 4'(count_reg)};
                            end
                            else
                            begin
                                re    = 1'b1;
                                raddr = {oldest_reg, q_item.element_index[ELEM_W-1:0]};
                                if (q_item.release_after)
                                begin
                                    oldest_next = next_slot(oldest_reg);
                                    count_next  = count_reg - 1'b1;
                                end
                                state_next = S_READ;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                rv_next  = 1'b1;
                                res_next = '{16'd0, ST_EMPTY, 4'(count_reg)};
                            end
                            else
                            begin
                                dvd_next   = {1'b0, q_item.angle_tenths, 1'b0}
                                             + DVD_W'(r);
                                dsr_next   = {r, 1'b0};
                                rem_next   = '0;
                                step_next  = '0;
                                state_next = S_DIV;
                            end
                        end
                        OP_CLEAR:
                        begin
                            oldest_next = '0;
                            wslot_next  = '0;
                            count_next  = '0;
                            fill_next   = '0;
                            rv_next     = 1'b1;
                            res_next    = '{16'd0, ST_OK, 4'd0};
                        end
                        default: ;
                    endcase
                end
            end
            S_PAD:
            begin
                we    = 1'b1;
                waddr = {wslot_reg, pad_reg[ELEM_W-1:0]};
                wdata = '0;
                if (pad_reg + 1'b1 >= e)
                begin
                    wslot_next = next_slot(wslot_reg);
                    count_next = count_reg + 1'b1;
                    fill_next  = '0;
                    rv_next    = 1'b1;
                    res_next   = '{16'd0, pend_reg, 4'(count_reg + 1'b1)};
                    state_next = S_IDLE;
                end
                else
                begin
                    pad_next = pad_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                // restoring divider, one quotient bit per cycle
                rem_next  = qbit ? DIV_W'(rem_s - {1'b0, dsr_reg}) : rem_s[DIV_W-1:0];
                dvd_next  = quot;
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(DVD_W - 1))
                begin
                    if (quot >= DVD_W'(e))
                    begin
                        rv_next    = 1'b1;
                        res_next   = '{16'd0, ST_RANGE, 4'(count_reg)};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = {oldest_reg, quot[ELEM_W-1:0]};
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rv_next    = 1'b1;
                res_next   = '{rdata_reg, ST_OK, 4'(count_reg)};
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        pad_reg  <= pad_next;
        pend_reg <= pend_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            oldest_reg <= '0;
            wslot_reg  <= '0;
            count_reg  <= '0;
            fill_reg   <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            wslot_reg  <= wslot_next;
            count_reg  <= count_next;
            fill_reg   <= fill_next;
            rv_reg     <= rv_next;
        end
    end

endmodule

@@ src/scan_ring_buffer_nearest_angle.sv @@
// ----------------------------------------------------------------------------
// scan_ring_buffer_nearest_angle
// Ring of laser scans with element reads and nearest-angle distance lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue port: a transfer happens when push is high
//   and full is low. A two-entry command queue decouples the input from the
//   execution engine. Each command yields exactly one result, shown on the
//   result ports while empty is low and taken when pop is high.
//   The resolution register is written over cfg_valid / cfg_ready (always
//   ready); write it only while the block is idle.
// Engine flow (one command at a time in the engine):
//   push, clear, read error, empty-ring query : handled in the idle state
//   element read                : registered memory read, then result
//   angle query                 : 13-step restoring divider, then read
//   angle query past scan end   : divider only
//   closing push of a short scan: one zero write per padded element
// The memory port (one write per cycle) sets the padding time.
// Reset clears pointers, counts and the queues; the scan memory is not
// cleared. When the receiver stalls, the result holds and the engine
// waits, while the command queue keeps taking up to two commands.
// ----------------------------------------------------------------------------
module scan_ring_buffer_nearest_angle
    import srbna_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [15:0] reading,
    input  logic        last_reading,
    input  logic [10:0] element_index,
    input  logic        release_after,
    input  logic [10:0] angle_tenths,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] distance_out,
    output logic [1:0]  status,
    output logic [3:0]  scans_stored,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  resolution_tenths
);

    logic [3:0] res_reg;
    item_t      in_item;
    item_t      q_item;
    logic       q_valid;
    logic       q_pop;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;

    // resolution register, reset to 1.0 degree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= 4'd10;
        else if (cfg_valid)
            res_reg <= resolution_tenths;
    end

    assign in_item = '{opcode, reading, last_reading, element_index,
                       release_after, angle_tenths};

    srbna_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    srbna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_cfg   (res_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty        = !res_valid;
    assign distance_out = res.distance;
    assign status       = res.status;
    assign scans_stored = res.count;

    // ring never reports more scans than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (scans_stored <= 4'(SLOTS)))
        else $error("scan count above slot count");

    // errors carry no distance
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_EMPTY || status == ST_RANGE)) |-> (distance_out == 16'd0))
        else $error("error result with nonzero distance");

    // empty-ring status only when no scans held
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_EMPTY) |-> (scans_stored == 4'd0))
        else $error("empty status with scans held");

endmodule
